[rtl/core/reversible_deque_defines.svh]
// ----------------------------------------------------------------------------
// reversible_deque_defines
// Assertion macros shared by the deque RTL.
// ----------------------------------------------------------------------------
`ifndef REVERSIBLE_DEQUE_DEFINES_SVH
`define REVERSIBLE_DEQUE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define RDQ_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("reversible_deque: same-cycle check failed");

// next-cycle implication, checked outside reset
`define RDQ_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("reversible_deque: next-cycle check failed");

`endif

[rtl/core/rdq_pkg.sv]
// ----------------------------------------------------------------------------
// rdq_pkg
// Types, codes and slot arithmetic for the reversible deque.
// ----------------------------------------------------------------------------
package rdq_pkg;

    localparam int CAPACITY = 16;
    localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int SUM_W    = ADDR_W + 1;
    localparam int WORD_W   = 32;
    localparam int MODE_W   = 3;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    typedef logic [ADDR_W-1:0]   slot_t;
    typedef logic [CNT_W-1:0]    cnt_t;
    typedef logic [WORD_W-1:0]   word_t;
    typedef logic [MODE_W-1:0]   mode_t;
    typedef logic [STATUS_W-1:0] status_t;

    localparam mode_t MODE_PUSH_BACK  = 3'd0;
    localparam mode_t MODE_PUSH_FRONT = 3'd1;
    localparam mode_t MODE_POP_BACK   = 3'd2;
    localparam mode_t MODE_POP_FRONT  = 3'd3;
    localparam mode_t MODE_TOGGLE     = 3'd4;

    localparam status_t STATUS_DONE      = 2'd0;
    localparam status_t STATUS_POP_EMPTY = 2'd1;
    localparam status_t STATUS_PUSH_FULL = 2'd2;

    localparam slot_t LAST_SLOT  = slot_t'(CAPACITY - 1);
    localparam cnt_t  FULL_CNT   = cnt_t'(CAPACITY);
    localparam word_t EMPTY_WORD = '1;

    // memory request issued with each transfer
    typedef struct packed {
        logic  wr_en;
        slot_t wr_addr;
        word_t wr_data;
        slot_t head_addr;
        slot_t tail_addr;
    } mem_cmd_t;

    // pointer state after the operation, carried alongside the read
    typedef struct packed {
        cnt_t    count;
        logic    reversed;
        status_t status;
    } step_info_t;

    // first slot plus an offset below the capacity, folded back into the ring
    function automatic slot_t slot_wrap(input logic [SUM_W-1:0] sum);
        logic [SUM_W-1:0] cap;
        cap = SUM_W'(CAPACITY);
        if (sum >= cap) begin
            return slot_t'(sum - cap);
        end
        return slot_t'(sum);
    endfunction

endpackage

[rtl/core/rdq_mem.sv]
// ----------------------------------------------------------------------------
// rdq_mem
// Word store: one write port, two registered read ports, write-first bypass.
// ----------------------------------------------------------------------------
module rdq_mem
    import rdq_pkg::*;
(
    input  logic     aclk,
    input  logic     rd_en,
    input  mem_cmd_t cmd,
    output word_t    head_q,
    output word_t    tail_q
);

    word_t store [CAPACITY];

    always_ff @(posedge aclk) begin
        if (cmd.wr_en) begin
            store[cmd.wr_addr] <= cmd.wr_data;
        end
    end

    // a push lands on the same slot that is read back in the same cycle
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            head_q <= (cmd.wr_en && cmd.wr_addr == cmd.head_addr) ? cmd.wr_data
                                                                   : store[cmd.head_addr];
            tail_q <= (cmd.wr_en && cmd.wr_addr == cmd.tail_addr) ? cmd.wr_data
                                                                   : store[cmd.tail_addr];
        end
    end

endmodule

[rtl/core/rdq_ctrl.sv]
// ----------------------------------------------------------------------------
// rdq_ctrl
// End pointers, count and reversal flag; decodes one operation per transfer.
// ----------------------------------------------------------------------------
module rdq_ctrl
    import rdq_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       accept,
    input  mode_t      mode,
    input  word_t      value,
    output mem_cmd_t   cmd,
    output step_info_t info
);

    slot_t first_reg, first_next;
    cnt_t  count_reg, count_next;
    logic  rev_reg, rev_next;

    status_t          status;
    logic             put_tail, put_head, drop_tail, drop_head;
    logic             full, empty;
    slot_t            slot_inc, slot_dec;
    logic [SUM_W-1:0] end_sum, tail_sum;

    always_comb begin
        put_tail  = (mode == MODE_PUSH_BACK  && !rev_reg) || (mode == MODE_PUSH_FRONT && rev_reg);
        put_head  = (mode == MODE_PUSH_FRONT && !rev_reg) || (mode == MODE_PUSH_BACK  && rev_reg);
        drop_tail = (mode == MODE_POP_BACK   && !rev_reg) || (mode == MODE_POP_FRONT  && rev_reg);
        drop_head = (mode == MODE_POP_FRONT  && !rev_reg) || (mode == MODE_POP_BACK   && rev_reg);
        full      = (count_reg == FULL_CNT);
        empty     = (count_reg == '0);
        slot_inc  = (first_reg == LAST_SLOT) ? '0 : first_reg + 1'b1;
        slot_dec  = (first_reg == '0) ? LAST_SLOT : first_reg - 1'b1;
        end_sum   = {1'b0, first_reg} + SUM_W'(count_reg);

        first_next  = first_reg;
        count_next  = count_reg;
        rev_next    = rev_reg;
        status      = STATUS_DONE;
        cmd.wr_en   = 1'b0;
        cmd.wr_addr = slot_wrap(end_sum);
        cmd.wr_data = value;

        if (put_tail || put_head) begin
            if (full) begin
                status = STATUS_PUSH_FULL;
            end else begin
                count_next = count_reg + 1'b1;
                cmd.wr_en  = 1'b1;
                if (put_head) begin
                    first_next  = slot_dec;
                    cmd.wr_addr = slot_dec;
                end
            end
        end else if (drop_tail || drop_head) begin
            if (empty) begin
                status = STATUS_POP_EMPTY;
            end else begin
                count_next = count_reg - 1'b1;
                // the last word out returns the ring to slot zero
                if (count_reg == cnt_t'(1)) begin
                    first_next = '0;
                end else if (drop_head) begin
                    first_next = slot_inc;
                end
            end
        end else if (mode == MODE_TOGGLE) begin
            rev_next = !rev_reg;
        end

        // tail slot is meaningless when the deque ends up empty
        tail_sum      = {1'b0, first_next} + SUM_W'(count_next) - SUM_W'(1);
        cmd.head_addr = first_next;
        cmd.tail_addr = slot_wrap(tail_sum);

        info.count    = count_next;
        info.reversed = rev_next;
        info.status   = status;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_reg <= '0;
            count_reg <= '0;
            rev_reg   <= 1'b0;
        end else if (accept) begin
            first_reg <= first_next;
            count_reg <= count_next;
            rev_reg   <= rev_next;
        end
    end

endmodule

[rtl/core/reversible_deque.sv]
// Throughput: one item per cycle while the m_ side is not stalled (m_tready
// high); the pointer update and the registered two-port read of the word store
// overlap, and the result is registered again before it appears on the m_ side.
// Reset (aresetn low, synchronous) clears the end pointers, count, reversal
// flag and both valid stages; the word store is not cleared.
// ----------------------------------------------------------------------------
// reversible_deque
// Double-ended queue of 32-bit words in a ring store, with a one-step reverse.
// ----------------------------------------------------------------------------
`include "reversible_deque_defines.svh"

module reversible_deque
    import rdq_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] value
    input  logic [2:0]  s_tuser,   // [2:0] mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // [31:0] front_value, [63:32] back_value,
                                   // [68:64] count, [69] is_empty, rest zero
    output logic [1:0]  m_tuser    // [1:0] status
);

    mem_cmd_t   cmd;
    step_info_t info;
    word_t      head_q, tail_q;
    logic       s_acc, advance, st1_empty;

    logic       st1_valid_reg;
    step_info_t st1_info_reg;

    logic       m_valid_reg, m_valid_next;
    word_t      out_front_reg, out_back_reg;
    cnt_t       out_count_reg;
    logic       out_empty_reg;
    status_t    out_status_reg;

    assign advance  = st1_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !st1_valid_reg || advance;
    assign s_acc    = s_tvalid && s_tready;

    rdq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (s_acc),
        .mode    (s_tuser),
        .value   (s_tdata[WORD_W-1:0]),
        .cmd     (cmd),
        .info    (info)
    );

    // read data holds while the stage is stalled
    rdq_mem u_mem (
        .aclk   (aclk),
        .rd_en  (s_acc),
        .cmd    (cmd),
        .head_q (head_q),
        .tail_q (tail_q)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg <= 1'b0;
        end else if (s_acc) begin
            st1_valid_reg <= 1'b1;
        end else if (advance) begin
            st1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            st1_info_reg <= info;
        end
    end

    assign st1_empty = (st1_info_reg.count == '0);

    always_comb begin
        m_valid_next = m_valid_reg;
        if (advance) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    // swap ends while reversed
    always_ff @(posedge aclk) begin
        if (advance) begin
            out_front_reg  <= st1_empty ? EMPTY_WORD
                            : (st1_info_reg.reversed ? tail_q : head_q);
            out_back_reg   <= st1_empty ? EMPTY_WORD
                            : (st1_info_reg.reversed ? head_q : tail_q);
            out_count_reg  <= st1_info_reg.count;
            out_empty_reg  <= st1_empty;
            out_status_reg <= st1_info_reg.status;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, out_empty_reg, COUNT_W'(out_count_reg), out_back_reg,
                       out_front_reg};
    assign m_tuser  = out_status_reg;

    `RDQ_ASSERT_NOW(a_count_in_range, st1_valid_reg, st1_info_reg.count <= FULL_CNT)
    `RDQ_ASSERT_NOW(a_full_status_only_when_full,
                    m_valid_reg && out_status_reg == STATUS_PUSH_FULL,
                    out_count_reg == FULL_CNT)
    `RDQ_ASSERT_NOW(a_empty_status_only_when_empty,
                    m_valid_reg && out_status_reg == STATUS_POP_EMPTY, out_empty_reg)
    `RDQ_ASSERT_NEXT(a_transfer_reaches_stage, s_acc, st1_valid_reg)

endmodule
